>>> rtl/core/iff_pkg.sv
// Shared types, constants and helpers of the integer field formatter.
`timescale 1ns / 1ps

package iff_pkg;

   // Character counts never exceed the 64-character field.
   localparam int LEN_W = 7;
   // Saturated precision fits in six bits.
   localparam int PREC_W = 6;

   // Digit store: 22 octal digits cover 64 bits, the longest case.
   localparam int DIG_NUM = 22;
   localparam int DIG_IDX_W = $clog2(DIG_NUM);
   localparam int NUM_W = $clog2(DIG_NUM + 1);

   // Decimal conversion: 20 BCD digits, two shift-add-3 steps per cycle.
   localparam int BCD_NUM = 20;
   localparam int VALUE_W = 64;
   localparam int DAB_STEPS = 2;
   localparam int CONV_CYCLES = VALUE_W / DAB_STEPS;
   localparam int STEP_W = $clog2(CONV_CYCLES);

   localparam int QUEUE_DEPTH = 2;

   // Conversion codes.
   localparam logic [2:0] CONV_DI = 3'd0;
   localparam logic [2:0] CONV_U = 3'd1;
   localparam logic [2:0] CONV_HEX_LO = 3'd2;
   localparam logic [2:0] CONV_HEX_UP = 3'd3;
   localparam logic [2:0] CONV_OCT = 3'd4;
   localparam logic [2:0] CONV_PTR = 3'd5;
   localparam logic [2:0] CONV_CHAR = 3'd6;
   localparam logic [2:0] CONV_NONE = 3'd7;

   // ASCII codes used in prefixes and padding.
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_X = 8'h58;

   localparam logic [0:15][7:0] HEX_LOWER = "0123456789abcdef";
   localparam logic [0:15][7:0] HEX_UPPER = "0123456789ABCDEF";

   // One conversion request as it arrives.
   typedef struct packed {
      logic [2:0]  conv;
      logic [63:0] value;
      logic        wide;
      logic        left_align;
      logic        force_plus;
      logic        space_sign;
      logic        alt_form;
      logic        zero_fill;
      logic [6:0]  field_width;
      logic [6:0]  precision;
   } iff_req_type;

   // A planned field: digits, prefix and the segment boundaries in character
   // positions. Leading spaces end at b1, the prefix at b2, zero fill at b3,
   // the digits at b4 and trailing spaces at total.
   typedef struct packed {
      logic [DIG_NUM-1:0][3:0] digits;
      logic                    upper;
      logic                    is_char;
      logic [7:0]              chr;
      logic [1:0][7:0]         pfx;
      logic [LEN_W-1:0]        b1;
      logic [LEN_W-1:0]        b2;
      logic [LEN_W-1:0]        b3;
      logic [LEN_W-1:0]        b4;
      logic [LEN_W-1:0]        total;
   } iff_job_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CONV,
      F_COUNT,
      F_PLAN,
      F_PUSH
   } iff_front_state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      return upper ? HEX_UPPER[d] : HEX_LOWER[d];
   endfunction

endpackage

>>> rtl/core/integer_field_formatter_top.sv
// Integer field formatter: renders a parsed printf integer conversion as ASCII beats.
// Decimal conversions (d, u) run through the two-bit-per-cycle binary-to-BCD loop before
// the field is planned; x, X, o, p and c take their digits straight from the value bits.
// The front end accepts a new conversion only after it has pushed the previous field; the
// back end emits one character per cycle while the sink accepts each beat, and the slower
// of the two sets the rate. Reset is synchronous and active high; it returns the front
// end to idle and empties the queue and the output stage.
`timescale 1ns / 1ps

module integer_field_formatter_top import iff_pkg::*; #(
   parameter int MAX_FIELD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_conv,
   input  logic [63:0]       req_value,
   input  logic              req_wide,
   input  logic              req_left_align,
   input  logic              req_force_plus,
   input  logic              req_space_sign,
   input  logic              req_alt_form,
   input  logic              req_zero_fill,
   input  logic [6:0]        req_field_width,
   input  logic signed [6:0] req_precision,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last
);

   // The front end decodes the request, converts the magnitude to digits and
   // plans where spaces, the prefix, zero fill and digits fall in the field.
   // Decimal digits come from an iterative binary-to-BCD loop; hex and octal
   // digits are bit slices of the value and need no conversion.
   iff_req_type req;
   logic        job_valid, job_ready;
   iff_job_type job;

   // The queue lets the front end plan the next conversion while the back
   // end is still streaming the previous field.
   logic        head_valid, head_ready;
   iff_job_type head;

   always_comb begin
      req.conv = req_conv;
      req.value = req_value;
      req.wide = req_wide;
      req.left_align = req_left_align;
      req.force_plus = req_force_plus;
      req.space_sign = req_space_sign;
      req.alt_form = req_alt_form;
      req.zero_fill = req_zero_fill;
      req.field_width = req_field_width;
      req.precision = $unsigned(req_precision);
   end

   iff_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   iff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_ready  (job_ready),
      .in_data   (job),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_data  (head)
   );

   // The back end reads the field at the queue head by character position and
   // releases it on the beat that carries the last character. Its output
   // register keeps taking characters while the sink accepts each beat.
   iff_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (head_valid),
      .job_ready    (head_ready),
      .job          (head),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

>>> rtl/core/iff_front.sv
// Front end: accepts a conversion, produces its digits and plans the field layout.
`timescale 1ns / 1ps

module iff_front import iff_pkg::*; #(
   parameter int MAX_FIELD = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  iff_req_type req,
   output logic        job_valid,
   input  logic        job_ready,
   output iff_job_type job
);

   localparam logic [LEN_W-1:0] WIDTH_CAP = LEN_W'(MAX_FIELD);
   localparam logic [PREC_W-1:0] PREC_CAP = PREC_W'(MAX_FIELD - 3);

   iff_front_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [VALUE_W-1:0] sh_ff, sh_in;
   logic [DIG_NUM-1:0][3:0] dig_ff, dig_in;
   logic is_hex_ff, is_hex_in;
   logic is_oct_ff, is_oct_in;
   logic is_char_ff, is_char_in;
   logic upper_ff, upper_in;
   logic neg_ff, neg_in;
   logic plus_ff, plus_in;
   logic space_ff, space_in;
   logic alt_ff, alt_in;
   logic left_ff, left_in;
   logic zmode_ff, zmode_in;
   logic mag_nz_ff, mag_nz_in;
   logic prec_given_ff, prec_given_in;
   logic [PREC_W-1:0] prec_ff, prec_in;
   logic [LEN_W-1:0] width_ff, width_in;
   logic [7:0] chr_ff, chr_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [PREC_W-1:0] zpad_ff, zpad_in;
   iff_job_type job_ff, job_in;

   // Request decode.
   logic [VALUE_W-1:0] ext;
   logic [VALUE_W-1:0] mag;
   logic [VALUE_W+1:0] ext_pad;
   logic neg;
   logic is_dec;
   logic [DIG_NUM-1:0][3:0] hex_dig, oct_dig;
   logic [PREC_W-1:0] req_prec;

   // Double dabble, digit count and layout.
   logic [BCD_NUM-1:0][3:0] bcd_t;
   logic [VALUE_W-1:0] sh_t;
   logic [NUM_W-1:0] n_cnt;
   logic [1:0] plen;
   logic [1:0][7:0] pfx;
   logic [LEN_W-1:0] content, pad, lead_sp, lead_zero, trail;

   always_comb begin
      if (!req.wide && req.conv != CONV_PTR) begin
         if (req.conv == CONV_DI) begin
            ext = {{32{req.value[31]}}, req.value[31:0]};
         end else begin
            ext = {32'b0, req.value[31:0]};
         end
      end else begin
         ext = req.value;
      end
      neg = (req.conv == CONV_DI) && ext[VALUE_W-1];
      mag = neg ? (~ext + 64'd1) : ext;
      is_dec = (req.conv == CONV_DI) || (req.conv == CONV_U);
      ext_pad = {2'b00, ext};
      hex_dig = '0;
      for (int i = 0; i < DIG_NUM; i++) begin
         oct_dig[i] = {1'b0, ext_pad[3*i +: 3]};
      end
      for (int i = 0; i < VALUE_W / 4; i++) begin
         hex_dig[i] = ext[4*i +: 4];
      end
      req_prec = (req.precision[5:0] > PREC_CAP) ? PREC_CAP : req.precision[5:0];
   end

   // Two binary-to-BCD steps per cycle.
   always_comb begin
      bcd_t = dig_ff[BCD_NUM-1:0];
      sh_t = sh_ff;
      for (int s = 0; s < DAB_STEPS; s++) begin
         for (int k = 0; k < BCD_NUM; k++) begin
            if (bcd_t[k] >= 4'd5) begin
               bcd_t[k] = bcd_t[k] + 4'd3;
            end
         end
         bcd_t = (4 * BCD_NUM)'({bcd_t, sh_t[VALUE_W-1]});
         sh_t = {sh_t[VALUE_W-2:0], 1'b0};
      end
   end

   // Significant digit count; a zero value still has one digit here.
   always_comb begin
      n_cnt = NUM_W'(1);
      for (int i = 0; i < DIG_NUM; i++) begin
         if (dig_ff[i] != 4'd0) begin
            n_cnt = NUM_W'(i + 1);
         end
      end
   end

   // Prefix and padding of the field.
   always_comb begin
      plen = 2'd0;
      pfx = {CH_ZERO, CH_ZERO};
      if (neg_ff) begin
         plen = 2'd1;
         pfx[0] = CH_MINUS;
      end else if (plus_ff) begin
         plen = 2'd1;
         pfx[0] = CH_PLUS;
      end else if (space_ff) begin
         plen = 2'd1;
         pfx[0] = CH_SPACE;
      end
      if (alt_ff) begin
         if (is_hex_ff && mag_nz_ff) begin
            plen = 2'd2;
            pfx[0] = CH_ZERO;
            pfx[1] = upper_ff ? CH_UPPER_X : CH_LOWER_X;
         end else if (is_oct_ff && zpad_ff == '0 && (n_ff == '0 || mag_nz_ff)) begin
            plen = 2'd1;
            pfx[0] = CH_ZERO;
         end
      end
      content = LEN_W'(plen) + LEN_W'(zpad_ff) + LEN_W'(n_ff);
      pad = (width_ff > content) ? (width_ff - content) : '0;
      lead_sp = (!left_ff && !zmode_ff) ? pad : '0;
      lead_zero = (zmode_ff ? pad : '0) + LEN_W'(zpad_ff);
      trail = left_ff ? pad : '0;
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      sh_in = sh_ff;
      dig_in = dig_ff;
      is_hex_in = is_hex_ff;
      is_oct_in = is_oct_ff;
      is_char_in = is_char_ff;
      upper_in = upper_ff;
      neg_in = neg_ff;
      plus_in = plus_ff;
      space_in = space_ff;
      alt_in = alt_ff;
      left_in = left_ff;
      zmode_in = zmode_ff;
      mag_nz_in = mag_nz_ff;
      prec_given_in = prec_given_ff;
      prec_in = prec_ff;
      width_in = width_ff;
      chr_in = chr_ff;
      n_in = n_ff;
      zpad_in = zpad_ff;
      job_in = job_ff;
      req_ready = 1'b0;
      job_valid = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req.conv != CONV_NONE) begin
               is_hex_in = (req.conv == CONV_HEX_LO) || (req.conv == CONV_HEX_UP) ||
                           (req.conv == CONV_PTR);
               is_oct_in = (req.conv == CONV_OCT);
               is_char_in = (req.conv == CONV_CHAR);
               upper_in = (req.conv == CONV_HEX_UP);
               neg_in = neg;
               plus_in = (req.conv == CONV_DI) && req.force_plus;
               space_in = (req.conv == CONV_DI) && req.space_sign;
               alt_in = req.alt_form || (req.conv == CONV_PTR);
               left_in = req.left_align;
               prec_given_in = !req.precision[6];
               prec_in = req_prec;
               zmode_in = !req.left_align && req.zero_fill && req.precision[6];
               mag_nz_in = (ext != '0);
               width_in = (req.field_width > WIDTH_CAP) ? WIDTH_CAP : req.field_width;
               chr_in = req.value[7:0];
               if (is_dec) begin
                  dig_in = '0;
                  sh_in = mag;
                  step_in = '0;
                  state_in = F_CONV;
               end else begin
                  dig_in = (req.conv == CONV_OCT) ? oct_dig : hex_dig;
                  state_in = F_COUNT;
               end
            end
         end
         F_CONV: begin
            dig_in[BCD_NUM-1:0] = bcd_t;
            sh_in = sh_t;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CONV_CYCLES - 1)) begin
               state_in = F_COUNT;
            end
         end
         F_COUNT: begin
            zpad_in = '0;
            if (is_char_ff) begin
               n_in = NUM_W'(1);
            end else begin
               if (prec_given_ff && prec_ff > PREC_W'(n_cnt)) begin
                  zpad_in = prec_ff - PREC_W'(n_cnt);
               end
               if (prec_given_ff && prec_ff == '0 && !mag_nz_ff) begin
                  n_in = '0;
               end else begin
                  n_in = n_cnt;
               end
            end
            state_in = F_PLAN;
         end
         F_PLAN: begin
            job_in.digits = dig_ff;
            job_in.upper = upper_ff;
            job_in.is_char = is_char_ff;
            job_in.chr = chr_ff;
            job_in.pfx = pfx;
            job_in.b1 = lead_sp;
            job_in.b2 = lead_sp + LEN_W'(plen);
            job_in.b3 = lead_sp + LEN_W'(plen) + lead_zero;
            job_in.b4 = lead_sp + LEN_W'(plen) + lead_zero + LEN_W'(n_ff);
            job_in.total = lead_sp + LEN_W'(plen) + lead_zero + LEN_W'(n_ff) + trail;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            // An empty field produces no beats and is dropped here.
            job_valid = (job_ff.total != '0);
            if (job_ff.total == '0 || job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      sh_ff <= sh_in;
      dig_ff <= dig_in;
      is_hex_ff <= is_hex_in;
      is_oct_ff <= is_oct_in;
      is_char_ff <= is_char_in;
      upper_ff <= upper_in;
      neg_ff <= neg_in;
      plus_ff <= plus_in;
      space_ff <= space_in;
      alt_ff <= alt_in;
      left_ff <= left_in;
      zmode_ff <= zmode_in;
      mag_nz_ff <= mag_nz_in;
      prec_given_ff <= prec_given_in;
      prec_ff <= prec_in;
      width_ff <= width_in;
      chr_ff <= chr_in;
      n_ff <= n_in;
      zpad_ff <= zpad_in;
      job_ff <= job_in;
   end

endmodule

>>> rtl/core/iff_queue.sv
// Short queue of planned fields between the front and back ends.
`timescale 1ns / 1ps

module iff_queue import iff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  iff_job_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output iff_job_type out_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   iff_job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic push, pop;

   always_comb begin
      in_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
      out_valid = (cnt_ff != '0);
      out_data = mem_ff[rd_ptr_ff];
      push = in_valid && in_ready;
      pop = out_valid && out_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/core/iff_back.sv
// Back end: walks a planned field and emits one character per beat.
`timescale 1ns / 1ps

module iff_back import iff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  iff_job_type job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic last_ff, last_in;

   logic load;
   logic last_now;
   logic [LEN_W-1:0] dig_off;
   logic [3:0] dig_val;
   logic [7:0] next_char;

   always_comb begin
      // Digits go out most significant first.
      dig_off = job.b4 - pos_ff - 1'b1;
      dig_val = (dig_off < LEN_W'(DIG_NUM)) ? job.digits[dig_off[DIG_IDX_W-1:0]] : 4'd0;

      priority if (pos_ff < job.b1) begin
         next_char = CH_SPACE;
      end else if (pos_ff < job.b2) begin
         next_char = (pos_ff == job.b1) ? job.pfx[0] : job.pfx[1];
      end else if (pos_ff < job.b3) begin
         next_char = CH_ZERO;
      end else if (pos_ff < job.b4) begin
         next_char = job.is_char ? job.chr : digit_char(dig_val, job.upper);
      end else begin
         next_char = CH_SPACE;
      end

      load = job_valid && (!rsp_valid_ff || rsp_ready);
      last_now = ((pos_ff + 1'b1) == job.total);
      job_ready = load && last_now;

      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (load) begin
         pos_in = last_now ? '0 : pos_ff + 1'b1;
         rsp_valid_in = 1'b1;
         char_in = next_char;
         last_in = last_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule
